// ----- sv/rbtb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbtb_pkg: shared types and constants
// framebuffer geometry, font table, command codes and sequencer states
// ----------------------------------------------------------------------------
package rbtb_pkg;

    localparam int RAW_WIDTH   = 800;
    localparam int RAW_HEIGHT  = 480;
    localparam int ROW_BYTES   = (RAW_WIDTH + 7) / 8;
    localparam int STORE_BYTES = ROW_BYTES * RAW_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int COORD_W     = 13;

    typedef enum logic [1:0] {
        CMD_GLYPH = 2'd0,
        CMD_RECT  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DOT,
        ST_PIX,
        ST_RD,
        ST_WR,
        ST_NEXT,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [9:0]  x_pos;
        logic [9:0]  y_pos;
        logic [7:0]  char_code;
        logic [3:0]  scale;
        logic [9:0]  rect_width;
        logic [9:0]  rect_height;
        logic        color_black;
        logic [15:0] byte_address;
    } req_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [10:0] next_cursor_x;
    } rsp_t;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } mem_req_t;

    // returns found flag and 35 glyph bits, row 0 first, msb of each row leftmost
    function automatic logic [35:0] font_lookup(input logic [7:0] code);
        logic [35:0] r;
        r = '0;
        unique case (code)
            8'h20: r = {1'b1, 35'd0};
            8'h2D: r = {1'b1, 5'd0, 5'd0, 5'd0, 5'd31, 5'd0, 5'd0, 5'd0};
            8'h3A: r = {1'b1, 5'd0, 5'd4, 5'd0, 5'd0, 5'd4, 5'd0, 5'd0};
            8'h30: r = {1'b1, 5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
            8'h31: r = {1'b1, 5'd4, 5'd12, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14};
            8'h32: r = {1'b1, 5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd8, 5'd31};
            8'h33: r = {1'b1, 5'd30, 5'd1, 5'd1, 5'd14, 5'd1, 5'd1, 5'd30};
            8'h34: r = {1'b1, 5'd2, 5'd6, 5'd10, 5'd18, 5'd31, 5'd2, 5'd2};
            8'h35: r = {1'b1, 5'd31, 5'd16, 5'd16, 5'd30, 5'd1, 5'd1, 5'd30};
            8'h36: r = {1'b1, 5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
            8'h37: r = {1'b1, 5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd8, 5'd8};
            8'h38: r = {1'b1, 5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
            8'h39: r = {1'b1, 5'd14, 5'd17, 5'd17, 5'd15, 5'd1, 5'd1, 5'd14};
            8'h41: r = {1'b1, 5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
            8'h42: r = {1'b1, 5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
            8'h43: r = {1'b1, 5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
            8'h44: r = {1'b1, 5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30};
            8'h45: r = {1'b1, 5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
            8'h46: r = {1'b1, 5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
            8'h47: r = {1'b1, 5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15};
            8'h48: r = {1'b1, 5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
            8'h49: r = {1'b1, 5'd14, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14};
            8'h4A: r = {1'b1, 5'd7, 5'd2, 5'd2, 5'd2, 5'd2, 5'd18, 5'd12};
            8'h4B: r = {1'b1, 5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17};
            8'h4C: r = {1'b1, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
            8'h4D: r = {1'b1, 5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
            8'h4E: r = {1'b1, 5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
            8'h4F: r = {1'b1, 5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
            8'h50: r = {1'b1, 5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
            8'h51: r = {1'b1, 5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13};
            8'h52: r = {1'b1, 5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
            8'h53: r = {1'b1, 5'd15, 5'd16, 5'd16, 5'd14, 5'd1, 5'd1, 5'd30};
            8'h54: r = {1'b1, 5'd31, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4};
            8'h55: r = {1'b1, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
            8'h56: r = {1'b1, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
            8'h57: r = {1'b1, 5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10};
            8'h58: r = {1'b1, 5'd17, 5'd17, 5'd10, 5'd4, 5'd10, 5'd17, 5'd17};
            8'h59: r = {1'b1, 5'd17, 5'd17, 5'd10, 5'd4, 5'd4, 5'd4, 5'd4};
            8'h5A: r = {1'b1, 5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd31};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/rbtb_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbtb_if: valid/ready channel
// carries one payload per transfer, source drives valid and data
// ----------------------------------------------------------------------------
interface rbtb_req_if;
    logic             valid;
    logic             ready;
    rbtb_pkg::req_t   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rbtb_rsp_if;
    logic             valid;
    logic             ready;
    rbtb_pkg::rsp_t   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/rotated_bitmap_text_blitter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_bitmap_text_blitter_top: rotated 5x7 text and rectangle drawing
// 1 bit per pixel framebuffer, drawn in portrait coordinates
//
// req channel takes a command: glyph, rectangle fill or byte read. rsp
// channel returns one result per command: the read byte and the next cursor x.
// One command at a time: req.ready is low from acceptance until the result
// has been transferred. Each drawn pixel passes through the pixel, read and
// write states on the single framebuffer port, each row of an area adds a
// row step and each area a closing step; each glyph dot adds a dot step and
// a next step. A read goes through the read and result states before its
// result is offered; the next command can be accepted in the cycle after
// its transfer. Reset clears the sequencer and the result register; the
// framebuffer is not cleared and must be painted with a full white
// rectangle first.
// A stalled receiver holds the result and keeps req.ready low.
// ----------------------------------------------------------------------------
module rotated_bitmap_text_blitter_top (
    input logic        clk,
    input logic        rst_n,
    rbtb_req_if.sink   req,
    rbtb_rsp_if.source rsp
);
    import rbtb_pkg::*;

    mem_req_t   mem;
    logic [7:0] mem_rdata;

    rbtb_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .mem       (mem),
        .mem_rdata (mem_rdata)
    );

    rbtb_frame_ram u_ram (
        .clk   (clk),
        .req   (mem),
        .rdata (mem_rdata)
    );

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && rsp.valid))
        else $error("request accepted while result pending");

    a_single_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem.rd_en && mem.wr_en))
        else $error("read and write in same cycle");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
        else $error("result dropped under stall");
endmodule

// ----- sv/rbtb_frame_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbtb_frame_ram: framebuffer byte store
// single port, registered read data
// ----------------------------------------------------------------------------
module rbtb_frame_ram (
    input  logic              clk,
    input  rbtb_pkg::mem_req_t req,
    output logic [7:0]        rdata
);
    import rbtb_pkg::*;

    logic [7:0] mem [STORE_BYTES];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rdata <= mem[req.addr];
        end
    end
endmodule

// ----- sv/rbtb_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbtb_seq: drawing sequencer
// walks glyph dots and pixels, one read-modify-write per pixel
// ----------------------------------------------------------------------------
module rbtb_seq (
    input  logic               clk,
    input  logic               rst_n,
    rbtb_req_if.sink           req,
    rbtb_rsp_if.source         rsp,
    output rbtb_pkg::mem_req_t mem,
    input  logic [7:0]         mem_rdata
);
    import rbtb_pkg::*;

    state_t state_reg, state_next;
    req_t   cur_reg, cur_next;
    logic [34:0] glyph_reg, glyph_next;
    logic [2:0]  row_reg, row_next;
    logic [2:0]  col_reg, col_next;
    logic [COORD_W-1:0] ox_reg, ox_next;
    logic [COORD_W-1:0] x1_reg, x1_next, y1_reg, y1_next;
    logic [COORD_W-1:0] px_reg, px_next, py_reg, py_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [7:0]  mask_reg, mask_next;
    logic [7:0]  rd_data_reg, rd_data_next;
    logic        is_glyph_reg, is_glyph_next;
    logic        black_reg, black_next;
    logic        rsp_valid_reg, rsp_valid_next;

    logic [35:0] font_bits;
    logic [COORD_W-1:0] sc_ext, xe, ye, ry;
    logic [COORD_W-1:0] pad_row;
    logic [ADDR_W+COORD_W-1:0] lin;
    logic dot_lit;

    assign font_bits = font_lookup(req.data.char_code);
    assign sc_ext  = COORD_W'(cur_reg.scale);
    assign dot_lit = glyph_reg[34 - (row_reg * 5 + col_reg)];
    assign ry      = COORD_W'(RAW_HEIGHT - 1) - px_reg;
    assign pad_row = ry;
    assign lin     = (ADDR_W+COORD_W)'(pad_row) * (ADDR_W+COORD_W)'(ROW_BYTES)
                   + (ADDR_W+COORD_W)'(py_reg >> 3);

    assign req.ready = (state_reg == ST_IDLE) && !rsp_valid_reg;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data.read_data = rd_data_reg;
    assign rsp.data.next_cursor_x = is_glyph_reg
        ? 11'(cur_reg.x_pos) + 11'(cur_reg.scale) * 11'd6
        : 11'(cur_reg.x_pos);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        glyph_reg    <= glyph_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        ox_reg       <= ox_next;
        x1_reg       <= x1_next;
        y1_reg       <= y1_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        addr_reg     <= addr_next;
        mask_reg     <= mask_next;
        rd_data_reg  <= rd_data_next;
        is_glyph_reg <= is_glyph_next;
        black_reg    <= black_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        glyph_next     = glyph_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        ox_next        = ox_reg;
        x1_next        = x1_reg;
        y1_next        = y1_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        addr_next      = addr_reg;
        mask_next      = mask_reg;
        rd_data_next   = rd_data_reg;
        is_glyph_next  = is_glyph_reg;
        black_next     = black_reg;
        rsp_valid_next = rsp_valid_reg;
        mem            = '0;
        xe             = '0;
        ye             = '0;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    cur_next      = req.data;
                    glyph_next    = font_bits[34:0];
                    row_next      = '0;
                    col_next      = '0;
                    rd_data_next  = '0;
                    is_glyph_next = (req.data.cmd == CMD_GLYPH);
                    unique case (cmd_t'(req.data.cmd))
                        CMD_GLYPH:
                        begin
                            black_next = 1'b1;
                            if (font_bits[35] && req.data.scale != '0)
                            begin
                                state_next = ST_DOT;
                            end
                            else
                            begin
                                state_next = ST_RESP;
                            end
                        end
                        CMD_RECT:
                        begin
                            black_next = req.data.color_black;
                            ox_next    = COORD_W'(req.data.x_pos);
                            x1_next    = COORD_W'(req.data.x_pos)
                                       + COORD_W'(req.data.rect_width);
                            y1_next    = COORD_W'(req.data.y_pos)
                                       + COORD_W'(req.data.rect_height);
                            px_next    = COORD_W'(req.data.x_pos);
                            py_next    = COORD_W'(req.data.y_pos);
                            state_next = ST_PIX;
                        end
                        CMD_READ:
                        begin
                            if (req.data.byte_address < 16'(STORE_BYTES))
                            begin
                                mem.rd_en  = 1'b1;
                                mem.addr   = ADDR_W'(req.data.byte_address);
                                state_next = ST_RD;
                                is_glyph_next = 1'b0;
                                black_next = 1'b0;
                                mask_next  = '0;
                                addr_next  = ADDR_W'(req.data.byte_address);
                            end
                            else
                            begin
                                state_next = ST_RESP;
                            end
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_DOT:
            begin
                // origin of this dot square
                xe = COORD_W'(cur_reg.x_pos) + COORD_W'(col_reg) * sc_ext;
                ye = COORD_W'(cur_reg.y_pos) + COORD_W'(row_reg) * sc_ext;
                ox_next = xe;
                x1_next = xe + sc_ext;
                y1_next = ye + sc_ext;
                px_next = xe;
                py_next = ye;
                if (dot_lit)
                begin
                    state_next = ST_PIX;
                end
                else
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_PIX:
            begin
                // clip: x against RAW_HEIGHT, y against RAW_WIDTH
                if (py_reg >= y1_reg || py_reg >= COORD_W'(RAW_WIDTH)
                    || ox_reg >= x1_reg)
                begin
                    state_next = cur_reg.cmd == CMD_GLYPH ? ST_NEXT : ST_RESP;
                end
                else if (px_reg >= x1_reg || px_reg >= COORD_W'(RAW_HEIGHT))
                begin
                    px_next = ox_reg;
                    py_next = py_reg + 1'b1;
                end
                else
                begin
                    addr_next  = ADDR_W'(lin);
                    mask_next  = 8'h80 >> py_reg[2:0];
                    mem.rd_en  = 1'b1;
                    mem.addr   = ADDR_W'(lin);
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                if (cur_reg.cmd == CMD_READ)
                begin
                    rd_data_next = mem_rdata;
                    state_next   = ST_RESP;
                end
                else
                begin
                    state_next = ST_WR;
                end
            end
            ST_WR:
            begin
                mem.wr_en  = 1'b1;
                mem.addr   = addr_reg;
                mem.wdata  = black_reg ? (mem_rdata & ~mask_reg) : (mem_rdata | mask_reg);
                px_next    = px_reg + 1'b1;
                state_next = ST_PIX;
            end
            ST_NEXT:
            begin
                if (col_reg == 3'd4)
                begin
                    col_next = '0;
                    if (row_reg == 3'd6)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        row_next   = row_reg + 1'b1;
                        state_next = ST_DOT;
                    end
                end
                else
                begin
                    col_next   = col_reg + 1'b1;
                    state_next = ST_DOT;
                end
            end
            ST_RESP:
            begin
                rsp_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

// ----- verif/rbtb_tb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbtb_tb_pkg: framebuffer predictor for the blitter testbench
// holds a private copy of the framebuffer and the font, and works out the
// read byte and next cursor x of each command as the block should
// ----------------------------------------------------------------------------
package rbtb_tb_pkg;
    import rbtb_pkg::*;

    localparam string GLYPH_CODES = " -:0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
    localparam int    GLYPH_COUNT = 39;

    typedef byte unsigned glyph_rows_t [7];

    const glyph_rows_t glyph_bitmaps [GLYPH_COUNT] = '{
        '{0,0,0,0,0,0,0},        '{0,0,0,31,0,0,0},       '{0,4,0,0,4,0,0},
        '{14,17,19,21,25,17,14}, '{4,12,4,4,4,4,14},      '{14,17,1,2,4,8,31},
        '{30,1,1,14,1,1,30},     '{2,6,10,18,31,2,2},     '{31,16,16,30,1,1,30},
        '{14,16,16,30,17,17,14}, '{31,1,2,4,8,8,8},       '{14,17,17,14,17,17,14},
        '{14,17,17,15,1,1,14},   '{14,17,17,31,17,17,17}, '{30,17,17,30,17,17,30},
        '{14,17,16,16,16,17,14}, '{30,17,17,17,17,17,30}, '{31,16,16,30,16,16,31},
        '{31,16,16,30,16,16,16}, '{14,17,16,23,17,17,15}, '{17,17,17,31,17,17,17},
        '{14,4,4,4,4,4,14},      '{7,2,2,2,2,18,12},      '{17,18,20,24,20,18,17},
        '{16,16,16,16,16,16,31}, '{17,27,21,21,17,17,17}, '{17,25,21,19,17,17,17},
        '{14,17,17,17,17,17,14}, '{30,17,17,30,16,16,16}, '{14,17,17,17,21,18,13},
        '{30,17,17,30,20,18,17}, '{15,16,16,14,1,1,30},   '{31,4,4,4,4,4,4},
        '{17,17,17,17,17,17,14}, '{17,17,17,17,17,10,4},  '{17,17,17,21,21,21,10},
        '{17,17,10,4,10,17,17},  '{17,17,10,4,4,4,4},     '{31,1,2,4,8,16,31}
    };

    class fb_predictor;
        logic [7:0] pixels [STORE_BYTES];

        function void plot(int px, int py, bit black);
            int idx;
            logic [7:0] mask;
            if (px >= RAW_HEIGHT || py >= RAW_WIDTH)
                return;
            idx  = (RAW_HEIGHT - 1 - px) * ROW_BYTES + (py >> 3);
            mask = 8'h80 >> (py & 7);
            if (black)
                pixels[idx] = pixels[idx] & ~mask;
            else
                pixels[idx] = pixels[idx] | mask;
        endfunction

        function void paint(int x0, int y0, int w, int h, bit black);
            int x1;
            int y1;
            x1 = (x0 + w > RAW_HEIGHT) ? RAW_HEIGHT : x0 + w;
            y1 = (y0 + h > RAW_WIDTH) ? RAW_WIDTH : y0 + h;
            for (int yy = y0; yy < y1; yy++)
                for (int xx = x0; xx < x1; xx++)
                    plot(xx, yy, black);
        endfunction

        function rsp_t apply(req_t r);
            rsp_t res;
            int   sel;
            int   sc;
            int   xp;
            int   yp;
            res.read_data     = '0;
            res.next_cursor_x = {1'b0, r.x_pos};
            sc = int'(r.scale);
            xp = int'(r.x_pos);
            yp = int'(r.y_pos);
            case (cmd_t'(r.cmd))
                CMD_GLYPH:
                begin
                    sel = -1;
                    for (int i = 0; i < GLYPH_COUNT; i++)
                        if (GLYPH_CODES[i] == r.char_code)
                            sel = i;
                    if (sel >= 0 && sc != 0)
                        for (int row = 0; row < 7; row++)
                            for (int col = 0; col < 5; col++)
                                if (glyph_bitmaps[sel][row][4 - col])
                                    paint(xp + col * sc, yp + row * sc, sc, sc, 1'b1);
                    res.next_cursor_x = 11'(r.x_pos) + 11'(6 * sc);
                end
                CMD_RECT:
                    paint(xp, yp, int'(r.rect_width), int'(r.rect_height), r.color_black);
                CMD_READ:
                    if (r.byte_address < STORE_BYTES)
                        res.read_data = pixels[r.byte_address];
                default:
                    ;
            endcase
            return res;
        endfunction
    endclass

endpackage

// ----- verif/tb_rotated_bitmap_text_blitter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotated_bitmap_text_blitter_top: self-checking bench for the blitter
// paints the screen white, runs a directed table then random glyph, fill and
// read commands under several idle and stall mixes, and checks each result
// against a framebuffer predictor
// ----------------------------------------------------------------------------
module tb_rotated_bitmap_text_blitter_top;
    import rbtb_pkg::*;
    import rbtb_tb_pkg::*;

    localparam int IDLE_LIMIT   = 6000000;
    localparam int RANDOM_ITEMS = 1250;
    localparam int HOLD_CYCLES  = 3000;

    typedef struct {
        req_t cmd_in;
        bit   typed;
        rsp_t want;
    } table_row_t;

    logic clk;
    logic rst_n;

    rbtb_req_if req_if ();
    rbtb_rsp_if rsp_if ();

    rotated_bitmap_text_blitter_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if.sink),
        .rsp   (rsp_if.source)
    );

    fb_predictor screen_model = new();
    rsp_t        pending_results [$];
    bit          typed_flags [$];
    rsp_t        typed_results [$];
    int          mismatches;
    int          idle_cycles;
    int          send_gap_pct;
    int          stall_pct;
    bit          hold_wanted;
    bit          hold_done;
    int          hold_left;
    int          n_glyph;
    int          n_fill;
    int          n_read;
    int          n_results;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        mismatches++;
    endtask

    function automatic req_t make_req(cmd_t c, int x, int y, int ch, int sc,
                                      int w, int h, bit black, int addr);
        req_t r;
        r.cmd          = c;
        r.x_pos        = 10'(x);
        r.y_pos        = 10'(y);
        r.char_code    = 8'(ch);
        r.scale        = 4'(sc);
        r.rect_width   = 10'(w);
        r.rect_height  = 10'(h);
        r.color_black  = black;
        r.byte_address = 16'(addr);
        return r;
    endfunction

    function automatic req_t random_req();
        req_t        r;
        int          pick;
        logic [95:0] bits;
        bits = {$urandom, $urandom, $urandom};
        r = req_t'(bits[$bits(req_t)-1:0]);
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            r.cmd = CMD_READ;
            if ($urandom_range(9) != 0)
                r.byte_address = 16'($urandom_range(STORE_BYTES - 1));
        end
        else if (pick < 75)
        begin
            r.cmd = CMD_GLYPH;
            if ($urandom_range(9) < 7)
                r.char_code = GLYPH_CODES[$urandom_range(GLYPH_COUNT - 1)];
            r.scale = 4'(($urandom_range(29) == 0) ? $urandom_range(15) : $urandom_range(4));
            if ($urandom_range(3) != 0)
            begin
                r.x_pos = 10'($urandom_range(479));
                r.y_pos = 10'($urandom_range(799));
            end
        end
        else if (pick < 95)
        begin
            r.cmd = CMD_RECT;
            case ($urandom_range(2))
                0:
                begin
                    r.rect_width  = 10'($urandom_range(16));
                    r.rect_height = 10'($urandom_range(16));
                end
                1:
                    r.rect_height = 10'($urandom_range(3));
                default:
                    r.rect_width = 10'($urandom_range(3));
            endcase
            if ($urandom_range(3) != 0)
            begin
                r.x_pos = 10'($urandom_range(479));
                r.y_pos = 10'($urandom_range(799));
            end
        end
        else
        begin
            r.cmd = CMD_NONE;
        end
        return r;
    endfunction

    // offer one command and return at the edge where it is accepted
    task automatic send_cmd(req_t r, bit typed, rsp_t want);
        if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        typed_flags.push_back(typed);
        typed_results.push_back(want);
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        @(negedge clk);
        while (!req_if.ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end
        else if (hold_wanted && !hold_done)
        begin
            hold_done    <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            rsp_if.ready <= !(stall_pct != 0 && $urandom_range(99) < stall_pct);
        end
    end

    // transfer monitor and checker
    always @(posedge clk)
    begin
        rsp_t pred;
        rsp_t got;
        rsp_t want;
        bit   typed;
        bit   moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (req_if.valid && req_if.ready)
            begin
                moved = 1'b1;
                pred  = screen_model.apply(req_if.data);
                typed = typed_flags.pop_front();
                want  = typed_results.pop_front();
                if (typed && want != pred)
                    report_mismatch("table row", int'(want), int'(pred));
                pending_results.push_back(typed ? want : pred);
                case (cmd_t'(req_if.data.cmd))
                    CMD_GLYPH: n_glyph++;
                    CMD_RECT:  n_fill++;
                    CMD_READ:  n_read++;
                    default:   ;
                endcase
            end
            if (rsp_if.valid && rsp_if.ready)
            begin
                moved = 1'b1;
                got = rsp_if.data;
                n_results++;
                if (pending_results.size() == 0)
                begin
                    report_mismatch("unexpected result", int'(got), 0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.read_data !== want.read_data)
                        report_mismatch("read_data", got.read_data, want.read_data);
                    if (got.next_cursor_x !== want.next_cursor_x)
                        report_mismatch("next_cursor_x", got.next_cursor_x,
                                        want.next_cursor_x);
                end
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        table_row_t rows [$];
        rsp_t       none;
        int         settle;
        none = '0;
        mismatches   = 0;
        idle_cycles  = 0;
        send_gap_pct = 0;
        stall_pct    = 0;
        hold_wanted  = 1'b0;
        n_glyph = 0; n_fill = 0; n_read = 0; n_results = 0;
        rst_n        = 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;

        // white screen first, so every byte is written before any read
        rows.push_back('{make_req(CMD_RECT, 0, 0, 0, 0, 480, 800, 0, 0), 1, 19'h0});
        rows.push_back('{make_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1, {8'hFF, 11'd0}});
        rows.push_back('{make_req(CMD_READ, 1023, 1023, 255, 15, 1023, 1023, 1, 47999),
                         1, {8'hFF, 11'd1023}});
        rows.push_back('{make_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 48000), 1, 19'h0});
        rows.push_back('{make_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 65535), 1, 19'h0});
        rows.push_back('{make_req(CMD_GLYPH, 0, 0, "0", 1, 0, 0, 0, 0), 1, {8'h0, 11'd6}});
        rows.push_back('{make_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 47900), 0, none});
        rows.push_back('{make_req(CMD_GLYPH, 100, 200, "W", 0, 0, 0, 0, 0),
                         1, {8'h0, 11'd100}});
        rows.push_back('{make_req(CMD_GLYPH, 1023, 1023, 255, 15, 0, 0, 0, 0),
                         1, {8'h0, 11'd1113}});
        rows.push_back('{make_req(CMD_GLYPH, 10, 10, "?", 3, 0, 0, 0, 0),
                         1, {8'h0, 11'd28}});
        rows.push_back('{make_req(CMD_NONE, 1023, 5, 0, 15, 9, 9, 1, 0),
                         1, {8'h0, 11'd1023}});
        rows.push_back('{make_req(CMD_GLYPH, 470, 795, "8", 3, 0, 0, 0, 0), 0, none});
        rows.push_back('{make_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 99), 0, none});
        rows.push_back('{make_req(CMD_GLYPH, 200, 300, "Z", 15, 0, 0, 0, 0), 0, none});
        rows.push_back('{make_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 259 * 100 + 37), 0, none});
        rows.push_back('{make_req(CMD_RECT, 1023, 1023, 0, 0, 1023, 1023, 1, 0),
                         1, {8'h0, 11'd1023}});
        rows.push_back('{make_req(CMD_RECT, 5, 5, 0, 0, 0, 40, 1, 0), 1, {8'h0, 11'd5}});
        rows.push_back('{make_req(CMD_RECT, 0, 0, 0, 0, 9, 17, 1, 0), 1, 19'h0});
        rows.push_back('{make_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 479 * 100), 0, none});
        rows.push_back('{make_req(CMD_RECT, 475, 796, 0, 0, 20, 20, 1, 0), 0, none});
        rows.push_back('{make_req(CMD_RECT, 2, 3, 0, 0, 4, 6, 0, 0), 0, none});
        rows.push_back('{make_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 99), 0, none});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_cmd(rows[i].cmd_in, rows[i].typed, rows[i].want);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 62; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 62; hold_wanted = 1'b1; end
                default: begin send_gap_pct = 37; stall_pct = 37; end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 4; n++)
                send_cmd(random_req(), 1'b0, none);
        end
        req_if.valid <= 1'b0;
        send_gap_pct = 0;
        stall_pct    = 0;

        while (pending_results.size() != 0)
            @(posedge clk);
        settle = 0;
        while (settle < 50)
        begin
            @(posedge clk);
            settle++;
        end

        $display("covered %0d glyphs, %0d fills, %0d reads; %0d results checked",
                 n_glyph, n_fill, n_read, n_results);
        $display("idle mixes: none, sender gaps, receiver stalls with a long hold, both");
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
